// File: rtl/assert_macros.svh
// assertion macros shared by the line position centroid rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define LPC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define LPC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/lpc_pkg.sv
// types, constants and control structs for the line position centroid core
`default_nettype none

package lpc_pkg;

  // field and accumulator widths
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned WSUM_W = 26;
  localparam int unsigned RSUM_W = 16;
  localparam int unsigned POS_W = 10;
  localparam int unsigned CHAN_W = 4;
  localparam int unsigned WEIGHT_W = 10;
  localparam int unsigned PROD_W = WEIGHT_W + SAMPLE_W;

  // restoring divider: one quotient bit per step
  localparam int unsigned DIV_STEPS = WSUM_W;
  localparam int unsigned DIVCNT_W = 5;

  // full scale of the position
  localparam int unsigned WEIGHT_SPAN = 1000;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [WSUM_W-1:0] wsum_t;
  typedef logic [RSUM_W-1:0] rsum_t;
  typedef logic [POS_W-1:0] pos_t;
  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [WEIGHT_W-1:0] weight_t;
  typedef logic [PROD_W-1:0] prod_t;
  typedef logic [DIVCNT_W-1:0] divcnt_t;

  localparam pos_t POS_MAX = 10'd1000;
  localparam pos_t POS_RESET = 10'd500;
  localparam sample_t THRESH_RESET = 12'd409;

  // controller to datapath commands
  typedef struct packed {
    logic load;      // input word accepted
    logic mul;       // read stored reading, form weight times reading
    logic acc;       // accumulate and advance the slot
    logic div_step;  // one divider iteration
    logic fin;       // close the frame
    logic out_load;  // capture the result word
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_compute;  // current slot is the compute slot
  } sts_t;

endpackage

`default_nettype wire

// File: rtl/lpc_ctrl.sv
// controller state machine for the line position centroid core
`default_nettype none

`include "assert_macros.svh"

module lpc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  input  wire lpc_pkg::sts_t sts,
  output lpc_pkg::cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ACC,
    S_DIV,
    S_FIN,
    S_OUT
  } state_t;

  state_t           state_r;
  lpc_pkg::divcnt_t div_cnt_r;
  logic             out_valid_r;
  logic             accept;
  logic             out_free;

  assign accept    = in_valid && (state_r == S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // command decode from state
  always_comb begin
    cmd          = '0;
    cmd.load     = accept;
    cmd.mul      = (state_r == S_MUL);
    cmd.acc      = (state_r == S_ACC);
    cmd.div_step = (state_r == S_DIV);
    cmd.fin      = (state_r == S_FIN);
    cmd.out_load = (state_r == S_OUT) && out_free;
  end

  // state, divider step count and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          div_cnt_r <= '0;
          if (accept) begin
            state_r <= sts.is_compute ? S_DIV : S_MUL;
          end
        end
        S_MUL: begin
          state_r <= S_ACC;
        end
        S_ACC: begin
          state_r <= S_OUT;
        end
        S_DIV: begin
          div_cnt_r <= div_cnt_r + 1'b1;
          if (div_cnt_r == lpc_pkg::divcnt_t'(lpc_pkg::DIV_STEPS - 1)) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // only one word in flight
  `LPC_ASSERT(a_busy_after_accept, accept |=> in_stall, "input accepted while busy")
  // closing a frame always leads straight to the output step
  `LPC_ASSERT(a_fin_to_out, (state_r == S_FIN) |=> (state_r == S_OUT), "fin not followed by out")
  // a new result word comes only from the output step
  `LPC_ASSERT(a_out_from_out_state, $rose(out_valid_r) |-> ($past(state_r) == S_OUT),
              "result raised outside output step")

endmodule

`default_nettype wire

// File: rtl/lpc_dpath.sv
// datapath: reading store, weighted sums, divider and result register
`default_nettype none

`include "assert_macros.svh"

module lpc_dpath #(
  parameter int unsigned SENSOR_COUNT = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_wr_en,
  input  wire lpc_pkg::sample_t cfg_wr_data,
  input  wire lpc_pkg::sample_t in_sample,
  input  wire logic             in_sample_valid,
  input  wire logic             in_emitter_on,
  input  wire lpc_pkg::cmd_t    cmd,
  output lpc_pkg::sts_t         sts,
  output lpc_pkg::pos_t         out_position,
  output logic                  out_frame_done,
  output lpc_pkg::chan_t        out_mux_channel,
  output logic                  out_emitter_enable
);

  localparam int unsigned SLOT_W = $clog2(SENSOR_COUNT + 1);
  localparam int unsigned IDX_W = $clog2(SENSOR_COUNT);

  lpc_pkg::weight_t  weight_tab [SENSOR_COUNT];
  lpc_pkg::sample_t  readings_r [SENSOR_COUNT];
  logic [SLOT_W-1:0] slot_r;
  logic [IDX_W-1:0]  idx;
  lpc_pkg::sample_t  thr_r;
  lpc_pkg::wsum_t    wsum_r;
  lpc_pkg::rsum_t    rsum_r;
  lpc_pkg::pos_t     pos_r;
  lpc_pkg::prod_t    prod_r;
  logic              over_r;
  lpc_pkg::rsum_t    rd_r;
  lpc_pkg::rsum_t    rem_r;
  lpc_pkg::wsum_t    quo_r;
  logic              emit_r;
  logic              done_r;
  logic              is_compute;
  logic [lpc_pkg::WSUM_W:0] wsum_add;
  logic [lpc_pkg::RSUM_W:0] rsum_add;
  lpc_pkg::wsum_t    wsum_nxt;
  lpc_pkg::rsum_t    rsum_nxt;
  logic [lpc_pkg::RSUM_W:0]   div_shl;
  logic [lpc_pkg::RSUM_W+1:0] div_diff;
  lpc_pkg::pos_t     pos_nxt;
  logic [7:0]        chan_full;
  lpc_pkg::pos_t     out_position_r;
  logic              out_frame_done_r;
  lpc_pkg::chan_t    out_mux_channel_r;
  logic              out_emitter_enable_r;

  // per-sensor weight floor(index * span / (count - 1)), fixed at elaboration
  for (genvar g = 0; g < SENSOR_COUNT; g++) begin : g_weight
    localparam int unsigned WVAL = (g * lpc_pkg::WEIGHT_SPAN) / (SENSOR_COUNT - 1);
    assign weight_tab[g] = lpc_pkg::weight_t'(WVAL);
  end

  assign idx            = slot_r[IDX_W-1:0];
  assign is_compute     = (slot_r == SLOT_W'(SENSOR_COUNT));
  assign sts.is_compute = is_compute;

  // saturating accumulation
  assign wsum_add = {1'b0, wsum_r} + (lpc_pkg::WSUM_W + 1)'(prod_r);
  assign rsum_add = {1'b0, rsum_r} + {1'b0, rd_r};
  assign wsum_nxt = wsum_add[lpc_pkg::WSUM_W] ? '1 : wsum_add[lpc_pkg::WSUM_W-1:0];
  assign rsum_nxt = rsum_add[lpc_pkg::RSUM_W] ? '1 : rsum_add[lpc_pkg::RSUM_W-1:0];

  // restoring divider step: shift in the next dividend bit, try subtract
  assign div_shl  = {rem_r, quo_r[lpc_pkg::WSUM_W-1]};
  assign div_diff = {1'b0, div_shl} - {2'b00, rsum_r};

  // quotient clamped to full scale
  assign pos_nxt = (quo_r > lpc_pkg::wsum_t'(lpc_pkg::POS_MAX)) ? lpc_pkg::POS_MAX
                                                               : quo_r[lpc_pkg::POS_W-1:0];

  // mux select for the next slot; the result word carries zero when the next slot is the compute slot
  assign chan_full = 8'(SENSOR_COUNT - 1) - 8'(slot_r);

  // control state: threshold, slot, sums, position, stored readings
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= lpc_pkg::THRESH_RESET;
      slot_r <= '0;
      wsum_r <= '0;
      rsum_r <= '0;
      pos_r  <= lpc_pkg::POS_RESET;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        readings_r[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        thr_r <= cfg_wr_data;
      end
      if (cmd.load && !is_compute && in_sample_valid) begin
        readings_r[idx] <= in_sample;
      end
      if (cmd.acc) begin
        if (over_r) begin
          wsum_r <= wsum_nxt;
          rsum_r <= rsum_nxt;
        end
        slot_r <= slot_r + 1'b1;
      end
      if (cmd.fin) begin
        if (rsum_r != '0) begin
          pos_r <= pos_nxt;
        end
        wsum_r <= '0;
        rsum_r <= '0;
        slot_r <= '0;
      end
    end
  end

  // working registers and result word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      emit_r <= in_emitter_on;
      done_r <= is_compute;
      rem_r  <= '0;
      quo_r  <= wsum_r;
    end
    if (cmd.mul) begin
      prod_r <= readings_r[idx] * weight_tab[idx];
      rd_r   <= lpc_pkg::rsum_t'(readings_r[idx]);
      over_r <= (readings_r[idx] > thr_r);
    end
    if (cmd.div_step) begin
      if (!div_diff[lpc_pkg::RSUM_W+1]) begin
        rem_r <= div_diff[lpc_pkg::RSUM_W-1:0];
        quo_r <= {quo_r[lpc_pkg::WSUM_W-2:0], 1'b1};
      end else begin
        rem_r <= div_shl[lpc_pkg::RSUM_W-1:0];
        quo_r <= {quo_r[lpc_pkg::WSUM_W-2:0], 1'b0};
      end
    end
    if (cmd.out_load) begin
      out_position_r       <= pos_r;
      out_frame_done_r     <= done_r;
      out_mux_channel_r    <= is_compute ? '0 : chan_full[lpc_pkg::CHAN_W-1:0];
      out_emitter_enable_r <= emit_r;
    end
  end

  assign out_position       = out_position_r;
  assign out_frame_done     = out_frame_done_r;
  assign out_mux_channel    = out_mux_channel_r;
  assign out_emitter_enable = out_emitter_enable_r;

  // the position never leaves full scale
  `LPC_ASSERT(a_pos_range, pos_r <= lpc_pkg::POS_MAX, "position above full scale")
  // every weighted contribution comes with a nonzero reading
  `LPC_ASSERT(a_sums_agree, (rsum_r == '0) |-> (wsum_r == '0), "weighted sum without readings")
  // the slot never runs past the compute slot
  `LPC_ASSERT(a_slot_range, slot_r <= SLOT_W'(SENSOR_COUNT), "slot past the compute slot")

endmodule

`default_nettype wire

// File: rtl/line_position_centroid_core.sv
// top level of the line position centroid core
`default_nettype none

// Line position by weighted centroid over a multiplexed bar of SENSOR_COUNT
// reflectance sensors. Each input word is one scan slot: slots 0 to
// SENSOR_COUNT-1 carry a sample for one sensor, the slot after them closes
// the frame and divides the weighted sum by the reading sum. One result word
// per input word. A sensor slot goes from acceptance to the result register
// through accept, read and multiply, accumulate and output; the compute slot
// goes through accept, the restoring divider at one quotient bit per cycle,
// frame close and output. The next word is taken the cycle after the
// result is loaded, so a result may still wait downstream while the next
// word is worked on. The threshold register is written through cfg_wr_en and
// cfg_wr_data; the stored readings clear at reset with no extra pass.
module line_position_centroid_core #(
  parameter int unsigned SENSOR_COUNT = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_wr_en,
  input  wire lpc_pkg::sample_t cfg_wr_data,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire lpc_pkg::sample_t in_sample,
  input  wire logic             in_sample_valid,
  input  wire logic             in_emitter_on,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output lpc_pkg::pos_t         out_position,
  output logic                  out_frame_done,
  output lpc_pkg::chan_t        out_mux_channel,
  output logic                  out_emitter_enable
);

  lpc_pkg::cmd_t cmd;
  lpc_pkg::sts_t sts;

  // slot sequencing and handshake
  lpc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // storage, arithmetic and result word
  lpc_dpath #(
    .SENSOR_COUNT (SENSOR_COUNT)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_sample          (in_sample),
    .in_sample_valid    (in_sample_valid),
    .in_emitter_on      (in_emitter_on),
    .cmd                (cmd),
    .sts                (sts),
    .out_position       (out_position),
    .out_frame_done     (out_frame_done),
    .out_mux_channel    (out_mux_channel),
    .out_emitter_enable (out_emitter_enable)
  );

endmodule

`default_nettype wire

// File: dv/line_position_centroid_core_test.sv
// self-checking testbench for the line position centroid core
`default_nettype none

module line_position_centroid_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SENSOR_COUNT = 16;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_COUNT = 6;
  localparam int unsigned PHASE_WORDS = 92;
  localparam int unsigned DIRECTED_WORDS = 25;
  localparam longint unsigned WSUM_MAX = (64'd1 << lpc_pkg::WSUM_W) - 1;
  localparam longint unsigned RSUM_MAX = (64'd1 << lpc_pkg::RSUM_W) - 1;

  // one result word as the block presents it
  typedef struct packed {
    lpc_pkg::pos_t  position;
    logic           frame_done;
    lpc_pkg::chan_t mux_channel;
    logic           emitter_enable;
  } result_word_t;

  // tracks scan state and the result words still owed by the block
  class line_position_tracker;
    lpc_pkg::sample_t threshold;
    int unsigned      slot;
    longint unsigned  weighted_sum;
    longint unsigned  reading_sum;
    lpc_pkg::pos_t    position;
    lpc_pkg::sample_t readings[SENSOR_COUNT];
    result_word_t     expected_words[$];
    int unsigned      errors;
    int unsigned      frames;

    function new();
      threshold = lpc_pkg::THRESH_RESET;
      slot = 0;
      weighted_sum = 0;
      reading_sum = 0;
      position = lpc_pkg::POS_RESET;
      foreach (readings[i]) readings[i] = '0;
      errors = 0;
      frames = 0;
    endfunction

    function void set_threshold(lpc_pkg::sample_t t);
      threshold = t;
    endfunction

    function int unsigned pending();
      return expected_words.size();
    endfunction

    // advance the scan by one accepted input word
    function void note_word(lpc_pkg::sample_t s, logic sv, logic em);
      result_word_t     w;
      lpc_pkg::sample_t rd;
      longint unsigned  add;
      longint unsigned  quot;
      w.frame_done = 1'b0;
      if (slot < SENSOR_COUNT) begin
        if (sv) readings[slot] = s;
        rd = readings[slot];
        // only readings strictly above the threshold count
        if (rd > threshold) begin
          add = longint'((slot * lpc_pkg::WEIGHT_SPAN) / (SENSOR_COUNT - 1)) * rd;
          weighted_sum = (add > WSUM_MAX - weighted_sum) ? WSUM_MAX : weighted_sum + add;
          reading_sum = (rd > RSUM_MAX - reading_sum) ? RSUM_MAX : reading_sum + rd;
        end
        slot++;
      end else begin
        // compute slot: an empty frame keeps the old position
        if (reading_sum != 0) begin
          quot = weighted_sum / reading_sum;
          position = (quot > lpc_pkg::POS_MAX) ? lpc_pkg::POS_MAX : lpc_pkg::pos_t'(quot);
        end
        slot = 0;
        weighted_sum = 0;
        reading_sum = 0;
        w.frame_done = 1'b1;
        frames++;
      end
      w.position = position;
      w.mux_channel = (slot < SENSOR_COUNT) ? lpc_pkg::chan_t'(SENSOR_COUNT - 1 - slot) : '0;
      w.emitter_enable = em;
      expected_words.push_back(w);
    endfunction

    function void compare_field(string what, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        errors++;
      end
    endfunction

    // compare one accepted result word with the oldest expectation
    function void check_word(result_word_t got);
      result_word_t want;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected result word, position %0d, frame_done %0b",
                 $time, got.position, got.frame_done);
        errors++;
        return;
      end
      want = expected_words.pop_front();
      compare_field("position", 16'(want.position), 16'(got.position));
      compare_field("frame_done", 16'(want.frame_done), 16'(got.frame_done));
      compare_field("mux_channel", 16'(want.mux_channel), 16'(got.mux_channel));
      compare_field("emitter_enable", 16'(want.emitter_enable), 16'(got.emitter_enable));
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_wr_en = 1'b0;
  lpc_pkg::sample_t cfg_wr_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  lpc_pkg::sample_t in_sample = '0;
  logic             in_sample_valid = 1'b0;
  logic             in_emitter_on = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  lpc_pkg::pos_t    out_position;
  logic             out_frame_done;
  lpc_pkg::chan_t   out_mux_channel;
  logic             out_emitter_enable;

  line_position_tracker tracker = new();

  int unsigned cycle_count = 0;
  int unsigned words_sent = 0;
  int unsigned results_seen = 0;
  int unsigned rx_hold = 0;
  bit          rx_quiet = 1'b0;
  bit          tx_quiet = 1'b0;
  int unsigned frame_style = 0;
  int unsigned line_center = 0;
  int unsigned line_width = 0;

  line_position_centroid_core #(
    .SENSOR_COUNT(SENSOR_COUNT)
  ) u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_sample          (in_sample),
    .in_sample_valid    (in_sample_valid),
    .in_emitter_on      (in_emitter_on),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_position       (out_position),
    .out_frame_done     (out_frame_done),
    .out_mux_channel    (out_mux_channel),
    .out_emitter_enable (out_emitter_enable)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // result side stall, counted down on the falling edge
  always @(negedge clk) begin
    if (rx_hold != 0) begin
      out_stall <= 1'b1;
      rx_hold = rx_hold - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // accept and check result words
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      tracker.check_word('{out_position, out_frame_done, out_mux_channel, out_emitter_enable});
      results_seen++;
      if (results_seen % 24 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
      rx_hold = rx_quiet ? 0 : $urandom_range(0, 12);
    end
  end

  // offer one scan word and hold it until accepted
  task automatic send_word(lpc_pkg::sample_t s, logic sv, logic em);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 12);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_sample <= s;
    in_sample_valid <= sv;
    in_emitter_on <= em;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    tracker.note_word(s, sv, em);
    words_sent++;
  endtask

  // stop sending until every owed result word has come back
  task automatic drain_words();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic write_threshold(lpc_pkg::sample_t t);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= t;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= lpc_pkg::sample_t'($urandom_range(0, 4095));
    tracker.set_threshold(t);
  endtask

  // sample for the current slot following the frame's profile
  function automatic lpc_pkg::sample_t shape_sample();
    int unsigned thr;
    int unsigned bright_lo;
    int unsigned line_offset;
    thr = tracker.threshold;
    bright_lo = (thr < 4095) ? thr + 1 : 4095;
    if (tracker.slot >= SENSOR_COUNT) return lpc_pkg::sample_t'($urandom_range(0, 4095));
    line_offset = (tracker.slot > line_center) ? tracker.slot - line_center
                                               : line_center - tracker.slot;
    if (frame_style < 6) begin
      // one dark line under a few adjacent sensors
      if (line_offset <= line_width) return lpc_pkg::sample_t'($urandom_range(4095, bright_lo));
      return lpc_pkg::sample_t'($urandom_range(thr, 0));
    end
    if (frame_style < 9) begin
      // scattered extremes and values at the threshold edge
      case ($urandom_range(0, 5))
        0: return '0;
        1: return 12'hFFF;
        2: return lpc_pkg::sample_t'(thr);
        3: return lpc_pkg::sample_t'(bright_lo);
        default: return lpc_pkg::sample_t'($urandom_range(0, 4095));
      endcase
    end
    return lpc_pkg::sample_t'($urandom_range(thr, 0));
  endfunction

  // stimulus
  initial begin
    lpc_pkg::sample_t dir_sample[DIRECTED_WORDS];
    logic             dir_valid[DIRECTED_WORDS];
    lpc_pkg::sample_t thr;
    int unsigned      pause_at;
    logic             sv;

    // first frame: extremes, threshold edge, kept reading, ignored compute input
    dir_sample = '{12'd0, 12'd4095, 12'd409, 12'd410, 12'd0, 12'h555, 12'hAAA, 12'd0,
                   12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd4095, 12'd4095,
                   12'd4095,
                   12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095,
                   12'd4095, 12'd4095};
    // second frame opens on kept readings only
    dir_valid = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
                  1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
                  1'b1,
                  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};

    // reset
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed words
    for (int i = 0; i < DIRECTED_WORDS; i++) begin
      send_word(dir_sample[i], dir_valid[i], i[0]);
    end

    // random phases, each under its own threshold
    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0: thr = '0;
        1: thr = 12'hFFF;
        PHASE_COUNT - 1: thr = lpc_pkg::THRESH_RESET;
        default: thr = lpc_pkg::sample_t'($urandom_range(1, 4094));
      endcase
      drain_words();
      write_threshold(thr);
      pause_at = $urandom_range(10, PHASE_WORDS - 10);
      for (int k = 0; k < PHASE_WORDS; k++) begin
        if (k == pause_at) drain_words();
        if (tracker.slot == 0) begin
          frame_style = $urandom_range(0, 9);
          line_center = $urandom_range(0, SENSOR_COUNT - 1);
          line_width = $urandom_range(0, 3);
          tx_quiet = ($urandom_range(0, 3) == 0);
        end
        sv = ($urandom_range(0, 7) != 0);
        send_word(shape_sample(), sv, 1'($urandom_range(0, 1)));
      end
    end

    // let the last results come back
    drain_words();
    repeat (40) @(posedge clk);

    $display("scan words sent: %0d, result words checked: %0d, frames closed: %0d",
             words_sent, results_seen, tracker.frames);
    $display("thresholds visited: reset, %0d phases incl. 0 and 4095, %0d cycles",
             PHASE_COUNT, cycle_count);
    if (tracker.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
